// File: hw/rtl/ptu_pkg.sv
// Package: shared types and constants for the particle table update block.
`timescale 1ns / 1ps
`default_nettype none
package ptu_pkg;
  localparam int unsigned VEC_W   = 48;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned LIFE_W  = 16;
  localparam int unsigned IDX_W   = 6;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [LIFE_W-1:0]    life;
    logic [VEC_W-1:0]     start_position;
    logic [VEC_W-1:0]     start_velocity;
    logic [VEC_W-1:0]     acceleration;
    logic [VEC_W-1:0]     scale_begin;
    logic [VEC_W-1:0]     scale_final;
    logic [COLOR_W-1:0]   color_begin;
    logic [COLOR_W-1:0]   color_final;
    logic                 parent_present;
    logic [VEC_W-1:0]     parent_offset;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   order_index;
    logic [VEC_W-1:0]   world_position;
    logic [VEC_W-1:0]   current_scale;
    logic [COLOR_W-1:0] current_color;
    logic               last;
  } out_item_t;

  // Lane-wise wrapping add of three Q8.8 components.
  function automatic logic [VEC_W-1:0] vec_add(input logic [VEC_W-1:0] a,
                                               input logic [VEC_W-1:0] b);
    logic [VEC_W-1:0] r;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      r[k*16 +: 16] = a[k*16 +: 16] + b[k*16 +: 16];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/ptu_if.sv
// Interfaces: valid/ready request channels for items and results.
`timescale 1ns / 1ps
`default_nettype none
interface ptu_in_if;
  logic               valid;
  logic               ready;
  ptu_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ptu_out_if;
  logic               valid;
  logic               ready;
  ptu_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/particle_table_update.sv
// Top level: particle table update block, front queue and back sequencer.
// Add request: popped from the queue and written into the table; no result.
// Tick request: compaction reads each live entry and keeps it or drops it, then
// each particle is read, updated, run through seven passes of the shared
// bit-serial divider and emitted; a stalled result holds the sequencer.
// One tick in flight at a time; a full queue of two requests stalls the input.
// Reset (rst_n low, synchronous) empties the queue and sets the live count to zero.
`timescale 1ns / 1ps
`default_nettype none
module particle_table_update #(
  parameter int unsigned MAX_PARTICLES = 64
) (
  input wire logic clk,
  input wire logic rst_n,
  ptu_in_if.sink    in_ch,
  ptu_out_if.source out_ch
);
  ptu_pkg::in_item_t q_data;
  logic q_valid, q_pop;

  // Front: hold requests until the back end is free.
  ptu_front u_front (.clk, .rst_n, .in_ch, .q_data, .q_valid, .q_pop);

  // Back: table storage and the per-particle sequencer.
  ptu_back #(.MAX_PARTICLES(MAX_PARTICLES)) u_back (
    .clk, .rst_n, .q_data, .q_valid, .q_pop, .out_ch);
endmodule
`default_nettype wire

// File: hw/rtl/ptu_front.sv
// Front end: accept requests and queue them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module ptu_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ptu_in_if.sink           in_ch,
  output ptu_pkg::in_item_t q_data,
  output logic             q_valid,
  input  wire logic        q_pop
);
  // Two-entry queue
  ptu_pkg::in_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_data      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_ch.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !in_ch.ready) else $error("ready while full");
endmodule
`default_nettype wire

// File: hw/rtl/ptu_div.sv
// Divider: signed dividend over unsigned 16-bit divisor, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module ptu_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [32:0] dividend,   // signed
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [32:0]      quotient    // signed, truncated toward zero
);
  logic [31:0] q_r;
  logic [16:0] rem_r;
  logic [15:0] d_r;
  logic        neg_r, busy_r;
  logic [5:0]  cnt_r;
  logic [16:0] trial;
  logic [31:0] mag;

  assign mag   = dividend[32] ? 32'(-dividend) : dividend[31:0];
  assign trial = {rem_r[15:0], q_r[31]};
  assign quotient = neg_r ? -{1'b0, q_r} : {1'b0, q_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done <= 1'b0; cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1; cnt_r <= 6'd32;
        q_r <= mag; rem_r <= '0; d_r <= divisor; neg_r <= dividend[32];
      end else if (busy_r) begin
        if (trial >= {1'b0, d_r}) begin
          rem_r <= trial - {1'b0, d_r};
          q_r   <= {q_r[30:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/ptu_back.sv
// Back end: particle table, compaction, update and interpolation sequencer.
`timescale 1ns / 1ps
`default_nettype none
module ptu_back #(
  parameter int unsigned MAX_PARTICLES = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire ptu_pkg::in_item_t q_data,
  input  wire logic         q_valid,
  output logic              q_pop,
  ptu_out_if.source         out_ch
);
  localparam int unsigned AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);

  typedef struct packed {
    logic [47:0] pos, vel, acc, sb, sf;
    logic [31:0] cb, cf;
    logic [15:0] life, age;
  } ent_t;

  localparam logic [3:0] S_IDLE = 4'd0, S_CRD = 4'd1, S_CWR = 4'd2,
                         S_URD = 4'd3, S_UCALC = 4'd4, S_DIV = 4'd5,
                         S_DWAIT = 4'd6, S_EMIT = 4'd7;

  ent_t mem_r [MAX_PARTICLES];
  ent_t rd_r, cur_r;
  logic [3:0]    state_r;
  logic [CW-1:0] live_r, i_r, w_r;
  logic [2:0]    lane_r;
  logic [47:0]   pos_out_r, scale_r;
  logic [31:0]   color_r;
  logic          par_r;
  logic [47:0]   poff_r;
  logic          dstart;
  logic          ddone;
  logic [32:0]   dividend, dq;
  logic [16:0]   diff;
  logic          out_valid_r;
  ptu_pkg::out_item_t out_r;
  logic [AW-1:0] rd_a;

  ptu_div u_div (.clk, .rst_n, .start(dstart), .dividend, .divisor(cur_r.life),
                 .done(ddone), .quotient(dq));

  // Lane selection: three scale lanes, then four colour channels.
  always_comb begin
    if (lane_r < 3'd3)
      diff = {cur_r.sf[lane_r*16+15], cur_r.sf[lane_r*16 +: 16]}
           - {cur_r.sb[lane_r*16+15], cur_r.sb[lane_r*16 +: 16]};
    else
      diff = {9'd0, cur_r.cf[(lane_r-3'd3)*8 +: 8]}
           - {9'd0, cur_r.cb[(lane_r-3'd3)*8 +: 8]};
    dividend = 33'($signed(diff) * $signed({1'b0, cur_r.age}));
  end

  assign dstart = (state_r == S_DIV);
  assign q_pop  = (state_r == S_IDLE) && q_valid &&
                  (q_data.kind == ptu_pkg::KIND_ADD || !out_valid_r);
  assign rd_a   = i_r[AW-1:0];
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    rd_r <= mem_r[rd_a];
    if (state_r == S_IDLE && q_pop && q_data.kind == ptu_pkg::KIND_ADD &&
        live_r != CW'(MAX_PARTICLES))
      mem_r[live_r[AW-1:0]] <= '{q_data.start_position, q_data.start_velocity,
        q_data.acceleration, q_data.scale_begin, q_data.scale_final,
        q_data.color_begin, q_data.color_final, q_data.life, 16'd0};
    else if (state_r == S_CWR && rd_r.age < rd_r.life)
      mem_r[w_r[AW-1:0]] <= rd_r;
    else if (state_r == S_EMIT)
      // write back the advanced particle once cur_r holds it
      mem_r[rd_a] <= cur_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; live_r <= '0; out_valid_r <= 1'b0;
      i_r <= '0; w_r <= '0; lane_r <= '0;
    end else begin
      if (state_r == S_EMIT && (!out_valid_r || out_ch.ready)) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (q_pop) begin
          if (q_data.kind == ptu_pkg::KIND_ADD) begin
            if (live_r != CW'(MAX_PARTICLES)) live_r <= live_r + CW'(1);
          end else begin
            par_r <= q_data.parent_present; poff_r <= q_data.parent_offset;
            i_r <= '0; w_r <= '0;
            state_r <= (live_r == '0) ? S_IDLE : S_CRD;
          end
        end
        S_CRD: state_r <= S_CWR;
        S_CWR: begin
          if (rd_r.age < rd_r.life) w_r <= w_r + CW'(1);
          if (i_r + CW'(1) == live_r) begin
            live_r  <= (rd_r.age < rd_r.life) ? w_r + CW'(1) : w_r;
            i_r     <= '0;
            state_r <= ((rd_r.age < rd_r.life) || w_r != '0) ? S_URD : S_IDLE;
          end else begin
            i_r <= i_r + CW'(1); state_r <= S_CRD;
          end
        end
        S_URD: state_r <= S_UCALC;
        S_UCALC: begin
          cur_r.age <= rd_r.age + 16'd1;
          cur_r.vel <= ptu_pkg::vec_add(rd_r.vel, rd_r.acc);
          cur_r.pos <= ptu_pkg::vec_add(rd_r.pos, ptu_pkg::vec_add(rd_r.vel, rd_r.acc));
          {cur_r.acc, cur_r.sb, cur_r.sf, cur_r.cb, cur_r.cf, cur_r.life} <=
            {rd_r.acc, rd_r.sb, rd_r.sf, rd_r.cb, rd_r.cf, rd_r.life};
          lane_r <= '0;
          state_r <= S_DIV;
        end
        S_DIV: state_r <= S_DWAIT;
        S_DWAIT: if (ddone) begin
          if (lane_r < 3'd3)
            scale_r[lane_r*16 +: 16] <= cur_r.sb[lane_r*16 +: 16] + dq[15:0];
          else
            color_r[(lane_r-3'd3)*8 +: 8] <= cur_r.cb[(lane_r-3'd3)*8 +: 8] + dq[7:0];
          if (lane_r == 3'd6) begin
            pos_out_r <= par_r ? ptu_pkg::vec_add(cur_r.pos, poff_r) : cur_r.pos;
            state_r <= S_EMIT;
          end else begin
            lane_r <= lane_r + 3'd1; state_r <= S_DIV;
          end
        end
        S_EMIT: if (!out_valid_r || out_ch.ready) begin
          out_r <= '{6'(i_r), pos_out_r, scale_r, color_r, (i_r + CW'(1) == live_r)};
          if (i_r + CW'(1) == live_r) state_r <= S_IDLE;
          else begin
            i_r <= i_r + CW'(1); state_r <= S_URD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CW'(MAX_PARTICLES)) else $error("live count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r) else $error("result dropped");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE) else $error("pop while busy");
  a_div_lane: assert property (@(posedge clk) disable iff (!rst_n)
    ddone |-> state_r == S_DWAIT) else $error("divider result unexpected");
endmodule
`default_nettype wire
